// File: hdl/hvn_pkg.sv
// Shared constants and types for the heightmap vertex normal block.
package hvn_pkg;

	localparam int GRID_DIM_DEF = 128;
	localparam int HEIGHT_BITS = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [7:0] GRID_WIDTH_RST = 8'd128;
	localparam logic [7:0] GRID_HEIGHT_RST = 8'd128;
	localparam logic [15:0] HEIGHT_SCALE_RST = 16'd2560;
	localparam logic [14:0] MAX_HEIGHT_RST = 15'd4096;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_WIDTH = 2'd0,
		REG_GRID_HEIGHT = 2'd1,
		REG_HEIGHT_SCALE = 2'd2,
		REG_MAX_HEIGHT = 2'd3
	} reg_index_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [23:0] UNIT_Y = 24'd4096;

endpackage

// File: hdl/heightmap_vertex_normal.sv
// Heightmap store with an iterative vertex-normal engine on one shared multiplier.
// A write is stored as it is accepted; a query gives its result beat after it walks the four
// faces: each face present takes a 31-step square root and three 15-step divisions, each
// absent face is skipped, and the result is then loaded into the output register.
// Throughput: one item at a time; a new item is taken only once the result is loaded.
// Reset: registers take their reset values, then a clearing pass over all GRID_DIM*GRID_DIM
// entries zeroes the store, during which no item is accepted.
module heightmap_vertex_normal #(
	parameter int GRID_DIM = hvn_pkg::GRID_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hvn_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hvn_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [6:0]                     col,
	input  logic [6:0]                     row,
	input  logic signed [15:0]             height_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             normal_x,
	output logic signed [15:0]             normal_y,
	output logic signed [15:0]             normal_z
);

	localparam int DEPTH = GRID_DIM * GRID_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int HB = hvn_pkg::HEIGHT_BITS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FACE, S_RX, S_RZ, S_MX, S_MZ, S_GZ,
		S_SQX, S_SQZ, S_SUM, S_SQRT, S_DIVI, S_DIV, S_ACC, S_OUT
	} state_t;

	state_t state_q;

	logic [7:0] grid_width_q, grid_height_q;
	logic [15:0] height_scale_q;
	logic [14:0] max_height_q;

	logic signed [HB-1:0] mem [DEPTH];
	logic signed [HB-1:0] rd_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] clr_q;

	logic [7:0] w_eff, h_eff;
	logic [6:0] x_q, y_q, fx_q, fy_q, nx_q, nz_q;
	logic fwdx_q, fwdz_q;
	logic [1:0] face_q, comp_q;
	logic signed [HB-1:0] here_q;
	logic signed [HB:0] diffx_q, diffz_q;
	logic signed [24:0] gx_q, gz_q;
	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] prod_q;
	logic [49:0] l2_q;
	logic [61:0] v_q, r_q, bit_q, sq_t;
	logic [44:0] rem_q, den_q;
	logic [14:0] qt_q;
	logic [3:0] step_q;
	logic neg_q;
	logic signed [17:0] acc_q [3];

	logic face_en;
	logic [6:0] fxc, fyc;
	logic in_range;
	logic signed [HB:0] hin_ext, lim_ext, clamped;
	logic signed [24:0] mag_sel;

	function automatic logic [AW-1:0] addr_of(input logic [6:0] ax, input logic [6:0] ay);
		addr_of = AW'(int'(ay) * GRID_DIM + int'(ax));
	endfunction

	// Divide by 256, rounding to nearest with ties away from zero.
	function automatic logic signed [24:0] rnd256(input logic signed [49:0] p);
		logic [49:0] m;
		m = p[49] ? 50'(-p) : 50'(p);
		m = (m + 50'd128) >> 8;
		rnd256 = p[49] ? -25'(m) : 25'(m);
	endfunction

	function automatic logic signed [15:0] avg(input logic signed [17:0] a, input logic [1:0] k);
		logic [17:0] m;
		logic [17:0] half;
		half = (k == 2'd0) ? 18'd0 : (18'd1 << (k - 2'd1));
		m = a[17] ? 18'(-a) : 18'(a);
		m = (m + half) >> k;
		avg = a[17] ? -16'(m) : 16'(m);
	endfunction

	always_comb begin
		w_eff = grid_width_q;
		if (grid_width_q < 8'd2) w_eff = 8'd2;
		else if (int'(grid_width_q) > GRID_DIM) w_eff = 8'(GRID_DIM);
		h_eff = grid_height_q;
		if (grid_height_q < 8'd2) h_eff = 8'd2;
		else if (int'(grid_height_q) > GRID_DIM) h_eff = 8'(GRID_DIM);
	end

	assign in_range = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);
	assign hin_ext = {height_in[15], height_in};
	assign lim_ext = {2'b00, max_height_q};
	always_comb begin
		clamped = hin_ext;
		if (hin_ext > lim_ext) clamped = lim_ext;
		if (hin_ext < -lim_ext) clamped = -lim_ext;
	end

	assign face_en = (face_q == 2'd0) || (face_q == 2'd1 && x_q != 7'd0)
		|| (face_q == 2'd2 && y_q != 7'd0)
		|| (face_q == 2'd3 && x_q != 7'd0 && y_q != 7'd0);
	assign fxc = face_q[0] ? x_q - 7'd1 : x_q;
	assign fyc = face_q[1] ? y_q - 7'd1 : y_q;

	always_comb begin
		case (state_q)
			S_RX: raddr = addr_of(nx_q, fy_q);
			S_RZ: raddr = addr_of(fx_q, nz_q);
			default: raddr = addr_of(fxc, fyc);
		endcase
	end

	// Shared multiplier operand selection.
	always_comb begin
		case (state_q)
			S_MX: begin
				mul_a = 25'(diffx_q);
				mul_b = $signed({9'd0, height_scale_q});
			end
			S_MZ: begin
				mul_a = 25'(diffz_q);
				mul_b = $signed({9'd0, height_scale_q});
			end
			S_SQX: begin
				mul_a = gx_q;
				mul_b = gx_q;
			end
			S_SQZ: begin
				mul_a = gz_q;
				mul_b = gz_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (comp_q)
			2'd0: mag_sel = gx_q;
			2'd2: mag_sel = gz_q;
			default: mag_sel = $signed({1'b0, hvn_pkg::UNIT_Y});
		endcase
	end

	assign sq_t = r_q + bit_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
		if (state_q == S_CLEAR) begin
			mem[clr_q] <= '0;
		end else if (state_q == S_IDLE && in_valid && in_range
				&& operation == hvn_pkg::OP_WRITE) begin
			mem[addr_of(col, row)] <= HB'(clamped);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= hvn_pkg::GRID_WIDTH_RST;
			grid_height_q <= hvn_pkg::GRID_HEIGHT_RST;
			height_scale_q <= hvn_pkg::HEIGHT_SCALE_RST;
			max_height_q <= hvn_pkg::MAX_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hvn_pkg::REG_GRID_WIDTH: grid_width_q <= cfg_data[7:0];
				hvn_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[7:0];
				hvn_pkg::REG_HEIGHT_SCALE: height_scale_q <= cfg_data;
				hvn_pkg::REG_MAX_HEIGHT: max_height_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			face_q <= '0;
			comp_q <= '0;
			step_q <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (int'(clr_q) == DEPTH - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && in_range && operation == hvn_pkg::OP_QUERY) begin
						x_q <= col;
						y_q <= row;
						face_q <= '0;
						acc_q[0] <= '0;
						acc_q[1] <= '0;
						acc_q[2] <= '0;
						state_q <= S_FACE;
					end
				end
				S_FACE: begin
					if (face_en) begin
						fx_q <= fxc;
						fy_q <= fyc;
						fwdx_q <= ({1'b0, fxc} + 8'd1) < w_eff;
						fwdz_q <= ({1'b0, fyc} + 8'd1) < h_eff;
						nx_q <= (({1'b0, fxc} + 8'd1) < w_eff) ? fxc + 7'd1 : fxc - 7'd1;
						nz_q <= (({1'b0, fyc} + 8'd1) < h_eff) ? fyc + 7'd1 : fyc - 7'd1;
						state_q <= S_RX;
					end else if (face_q == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						face_q <= face_q + 2'd1;
					end
				end
				S_RX: begin
					here_q <= rd_q;
					state_q <= S_RZ;
				end
				S_RZ: begin
					diffx_q <= fwdx_q ? ($signed({here_q[HB-1], here_q}) - $signed({rd_q[HB-1], rd_q}))
						: ($signed({rd_q[HB-1], rd_q}) - $signed({here_q[HB-1], here_q}));
					state_q <= S_MX;
				end
				S_MX: begin
					diffz_q <= fwdz_q ? ($signed({here_q[HB-1], here_q}) - $signed({rd_q[HB-1], rd_q}))
						: ($signed({rd_q[HB-1], rd_q}) - $signed({here_q[HB-1], here_q}));
					prod_q <= mul_a * mul_b;
					state_q <= S_MZ;
				end
				S_MZ: begin
					gx_q <= rnd256(prod_q);
					prod_q <= mul_a * mul_b;
					state_q <= S_GZ;
				end
				S_GZ: begin
					gz_q <= rnd256(prod_q);
					state_q <= S_SQX;
				end
				S_SQX: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_SQZ;
				end
				S_SQZ: begin
					l2_q <= 50'(prod_q) + (50'd1 << 24);
					prod_q <= mul_a * mul_b;
					state_q <= S_SUM;
				end
				S_SUM: begin
					v_q <= {l2_q + 50'(prod_q), 12'd0};
					r_q <= '0;
					bit_q <= 62'd1 << 60;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					// One result bit of the integer square root per cycle.
					if (v_q >= sq_t) begin
						v_q <= v_q - sq_t;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						comp_q <= '0;
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					neg_q <= mag_sel[24];
					rem_q <= ({(mag_sel[24] ? 24'(-mag_sel) : 24'(mag_sel)), 20'd0, 1'b0} >> 1)
						+ 45'(r_q[30:1]);
					den_q <= {r_q[30:0], 14'd0};
					qt_q <= '0;
					step_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (rem_q >= den_q) begin
						rem_q <= rem_q - den_q;
						qt_q <= {qt_q[13:0], 1'b1};
					end else begin
						qt_q <= {qt_q[13:0], 1'b0};
					end
					den_q <= den_q >> 1;
					step_q <= step_q + 4'd1;
					if (step_q == 4'd14) state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q[comp_q] <= neg_q ? acc_q[comp_q] - $signed({3'd0, qt_q})
						: acc_q[comp_q] + $signed({3'd0, qt_q});
					if (comp_q == 2'd2) begin
						if (face_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							face_q <= face_q + 2'd1;
							state_q <= S_FACE;
						end
					end else begin
						comp_q <= comp_q + 2'd1;
						state_q <= S_DIVI;
					end
				end
				S_OUT: begin
					// Hold the result until the output register is free.
					if (!out_valid || out_ready) begin
						normal_x <= avg(acc_q[0], {1'b0, x_q != 7'd0} + {1'b0, y_q != 7'd0});
						normal_y <= avg(acc_q[1], {1'b0, x_q != 7'd0} + {1'b0, y_q != 7'd0});
						normal_z <= avg(acc_q[2], {1'b0, x_q != 7'd0} + {1'b0, y_q != 7'd0});
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
